// ----- rtl/ftba_pkg.sv -----
`default_nettype none
package ftba_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned CPU_W = 8;
  localparam int unsigned MEM_W = 32;
  localparam int unsigned ID_W  = 8;

  localparam logic [CPU_W-1:0] RESET_CPU_CAPACITY = CPU_W'(8);
  localparam logic [MEM_W-1:0] RESET_MEM_CAPACITY = MEM_W'(64'd1 << 30);

  // configuration register indexes
  localparam logic CFG_CPU_CAPACITY = 1'b0;
  localparam logic CFG_MEM_CAPACITY = 1'b1;

  // request actions
  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    KIND_GRANT    = 2'd0,
    KIND_QUEUED   = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_RELEASED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ACQ,
    ST_RD,
    ST_FIT,
    ST_EMIT,
    ST_TAKE
  } state_e;

  typedef struct packed {
    logic [MEM_W-1:0] mem;
    logic [CPU_W-1:0] cpu;
    logic [ID_W-1:0]  id;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;  // capture the incoming beat
    logic prep;      // clamp an acquire, or return a release
    logic acquire;   // decide grant / queue / reject and emit
    logic rd;        // read the queue head
    logic fit_chk;   // register whether the head fits
    logic emit;      // emit the staged beat
    logic take;      // grant the head and pop it
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic is_release;
    logic head_fit;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/ftba_ctrl.sv -----
`default_nettype none
module ftba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ftba_pkg::sts_t sts_i,
  output ftba_pkg::cmd_t     cmd_o
);

  ftba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ftba_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ftba_pkg::ST_PREP;
        end
      end
      ftba_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.is_release ? ftba_pkg::ST_RD : ftba_pkg::ST_ACQ;
      end
      ftba_pkg::ST_ACQ: begin
        if (sts_i.out_free) begin
          cmd_o.acquire = 1'b1;
          state_d       = ftba_pkg::ST_IDLE;
        end
      end
      ftba_pkg::ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ftba_pkg::ST_FIT;
      end
      ftba_pkg::ST_FIT: begin
        cmd_o.fit_chk = 1'b1;
        state_d       = ftba_pkg::ST_EMIT;
      end
      ftba_pkg::ST_EMIT: begin
        // the staged beat is last unless the head can be granted next
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.head_fit ? ftba_pkg::ST_TAKE : ftba_pkg::ST_IDLE;
        end
      end
      ftba_pkg::ST_TAKE: begin
        cmd_o.take = 1'b1;
        state_d    = ftba_pkg::ST_RD;
      end
      default: begin
        state_d = ftba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/ftba_dp.sv -----
`default_nettype none
module ftba_dp #(
  parameter int unsigned QueueDepth = ftba_pkg::QUEUE_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [ftba_pkg::MEM_W-1:0] cfg_data_i,
  input  wire logic                      in_act_i,
  input  wire logic [47:0]               in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     out_kind_o,
  output logic [87:0]                    out_data_o,
  output logic                           out_last_o,
  input  wire ftba_pkg::cmd_t            cmd_i,
  output ftba_pkg::sts_t                 sts_o
);

  localparam int unsigned CpuW = ftba_pkg::CPU_W;
  localparam int unsigned MemW = ftba_pkg::MEM_W;
  localparam int unsigned IdW  = ftba_pkg::ID_W;
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  logic [CpuW-1:0] cpu_cap_q, cpu_used_q, cpu_used_d;
  logic [MemW-1:0] mem_cap_q, mem_used_q, mem_used_d;

  logic            req_act_q;
  ftba_pkg::entry_t req_q;
  ftba_pkg::entry_t beat_q;
  ftba_pkg::kind_e  beat_kind_q;
  ftba_pkg::entry_t rd_q;
  logic            fit_q;

  ftba_pkg::entry_t queue_mem [QueueDepth];
  logic [PtrW-1:0] head_q, tail_q;
  logic [CntW-1:0] count_q;

  logic            out_valid_q;
  logic [1:0]      out_kind_q;
  logic [87:0]     out_data_q;
  logic            out_last_q;

  logic            out_free;
  logic            req_fit, head_fit, q_empty, q_full;
  logic [CpuW-1:0] clamp_cpu;
  logic [MemW-1:0] clamp_mem;
  ftba_pkg::entry_t in_entry;

  function automatic logic fits(input logic [CpuW-1:0] used_c, input logic [CpuW-1:0] c,
                                input logic [CpuW-1:0] cap_c, input logic [MemW-1:0] used_m,
                                input logic [MemW-1:0] m, input logic [MemW-1:0] cap_m);
    logic [CpuW:0] sum_c;
    logic [MemW:0] sum_m;
    sum_c = {1'b0, used_c} + {1'b0, c};
    sum_m = {1'b0, used_m} + {1'b0, m};
    return (sum_c <= {1'b0, cap_c}) && (sum_m <= {1'b0, cap_m});
  endfunction

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign in_entry = ftba_pkg::entry_t'(in_data_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign q_empty  = (count_q == '0);
  assign q_full   = (count_q == CntFull);
  assign req_fit  = fits(cpu_used_q, req_q.cpu, cpu_cap_q, mem_used_q, req_q.mem, mem_cap_q);
  assign head_fit = !q_empty &&
                    fits(cpu_used_q, rd_q.cpu, cpu_cap_q, mem_used_q, rd_q.mem, mem_cap_q);

  // clamp an acquire: cpu to 1..capacity, memory to at most capacity
  always_comb begin
    clamp_cpu = req_q.cpu;
    if (clamp_cpu == '0) begin
      clamp_cpu = CpuW'(1);
    end
    if (clamp_cpu > cpu_cap_q) begin
      clamp_cpu = cpu_cap_q;
    end
    clamp_mem = (req_q.mem > mem_cap_q) ? mem_cap_q : req_q.mem;
  end

  always_comb begin
    cpu_used_d = cpu_used_q;
    mem_used_d = mem_used_q;
    if (cmd_i.prep && req_act_q == ftba_pkg::ACT_RELEASE) begin
      cpu_used_d = (cpu_used_q > req_q.cpu) ? cpu_used_q - req_q.cpu : '0;
      mem_used_d = (mem_used_q > req_q.mem) ? mem_used_q - req_q.mem : '0;
    end else if (cmd_i.acquire && q_empty && req_fit) begin
      cpu_used_d = cpu_used_q + req_q.cpu;
      mem_used_d = mem_used_q + req_q.mem;
    end else if (cmd_i.take) begin
      cpu_used_d = cpu_used_q + rd_q.cpu;
      mem_used_d = mem_used_q + rd_q.mem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_cap_q   <= ftba_pkg::RESET_CPU_CAPACITY;
      mem_cap_q   <= ftba_pkg::RESET_MEM_CAPACITY;
      cpu_used_q  <= '0;
      mem_used_q  <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a capacity written as zero acts as one
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ftba_pkg::CFG_CPU_CAPACITY: begin
            cpu_cap_q <= (cfg_data_i[CpuW-1:0] == '0) ? CpuW'(1) : cfg_data_i[CpuW-1:0];
          end
          ftba_pkg::CFG_MEM_CAPACITY: begin
            mem_cap_q <= (cfg_data_i == '0) ? MemW'(1) : cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      cpu_used_q <= cpu_used_d;
      mem_used_q <= mem_used_d;
      if (cmd_i.acquire && !(q_empty && req_fit) && !q_full) begin
        tail_q  <= ptr_inc(tail_q);
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.take) begin
        head_q  <= ptr_inc(head_q);
        count_q <= count_q - CntW'(1);
      end
      if (cmd_i.acquire || cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.acquire && !(q_empty && req_fit) && !q_full) begin
      queue_mem[tail_q] <= req_q;
    end
    if (cmd_i.rd) begin
      rd_q <= queue_mem[head_q];
    end
  end

  // request, staged beat and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_act_q <= in_act_i;
      req_q     <= in_entry;
    end
    if (cmd_i.prep) begin
      if (req_act_q == ftba_pkg::ACT_ACQUIRE) begin
        req_q.cpu <= clamp_cpu;
        req_q.mem <= clamp_mem;
      end else begin
        beat_q      <= req_q;
        beat_kind_q <= ftba_pkg::KIND_RELEASED;
      end
    end
    if (cmd_i.take) begin
      beat_q      <= rd_q;
      beat_kind_q <= ftba_pkg::KIND_GRANT;
    end
    if (cmd_i.fit_chk) begin
      fit_q <= head_fit;
    end
    if (cmd_i.acquire) begin
      if (q_empty && req_fit) begin
        out_kind_q <= ftba_pkg::KIND_GRANT;
      end else if (q_full) begin
        out_kind_q <= ftba_pkg::KIND_REJECTED;
      end else begin
        out_kind_q <= ftba_pkg::KIND_QUEUED;
      end
      out_data_q <= {mem_used_d, cpu_used_d, req_q.mem, req_q.cpu, req_q.id};
      out_last_q <= 1'b1;
    end else if (cmd_i.emit) begin
      out_kind_q <= beat_kind_q;
      out_data_q <= {mem_used_q, cpu_used_q, beat_q.mem, beat_q.cpu, beat_q.id};
      out_last_q <= !fit_q;
    end
  end

  assign sts_o.out_free   = out_free;
  assign sts_o.is_release = (req_act_q == ftba_pkg::ACT_RELEASE);
  assign sts_o.head_fit   = fit_q;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ----- rtl/fifo_two_budget_admission_unit.sv -----
`default_nettype none
// Two-budget admission controller (CPU slots and memory bytes), served in
// arrival order. An acquire beat (tuser 0) is clamped, then granted at once
// if nothing waits and it fits, else queued, or rejected when the queue is
// full; it gives one result beat. A release beat (tuser 1) returns its
// amounts (saturating at zero) and gives a release-done beat followed by one
// grant beat per queued head that now fits; tlast marks the final beat. The
// unit handles one request at a time under a controller. Before each
// release-done or grant beat is presented it does a registered read of the
// queue head and a fit check, so that tlast is known. The next input beat is
// accepted once the final result is staged; a stalled output holds the unit
// until the waiting beat can be staged. The user must write capacities
// through the cfg port only while the unit is idle; the unit itself does
// not enforce this. A capacity written as 0 acts as 1.
module fifo_two_budget_admission_unit #(
  parameter int unsigned QueueDepth = ftba_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // requester_id [7:0], cpu_count [15:8], mem_amount [47:16]
  input  wire logic [47:0] s_axis_tdata,
  // action
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // granted_id [7:0], granted_cpu [15:8], granted_memory [47:16],
  // cpu_in_use [55:48], memory_in_use [87:56]
  output logic [87:0]      m_axis_tdata,
  // kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  ftba_pkg::cmd_t cmd;
  ftba_pkg::sts_t sts;

  ftba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftba_dp #(
    .QueueDepth (QueueDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_act_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

// ----- tb/sv/fifo_two_budget_admission_unit_tb.sv -----
`timescale 1ns / 1ps

module fifo_two_budget_admission_unit_tb;
  import ftba_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [7:0]  id;
    logic [7:0]  cpu;
    logic [31:0] mem;
    logic [7:0]  cpu_use;
    logic [31:0] mem_use;
    logic        last;
  } admit_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_CPU_CAPACITY;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = ACT_ACQUIRE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  fifo_two_budget_admission_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // shadow of the admission state
  logic [7:0]  cap_cpu = RESET_CPU_CAPACITY;
  logic [31:0] cap_mem = RESET_MEM_CAPACITY;
  logic [7:0]  used_cpu = '0;
  logic [31:0] used_mem = '0;
  entry_t      wait_q [QUEUE_DEPTH];
  int unsigned wait_head = 0;
  int unsigned wait_count = 0;

  admit_beat_t expected_beats[$];
  entry_t      leases[$];
  int unsigned errors = 0;
  bit          gaps_on = 1'b1;
  int unsigned rx_hold_req = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit budget_fits(logic [7:0] c, logic [31:0] m);
    return ({1'b0, used_cpu} + 9'(c) <= {1'b0, cap_cpu}) &&
           ({1'b0, used_mem} + 33'(m) <= {1'b0, cap_mem});
  endfunction

  function automatic void push_beat(kind_e k, logic [7:0] id, logic [7:0] c,
                                    logic [31:0] m, logic last);
    admit_beat_t b;
    b.kind    = k;
    b.id      = id;
    b.cpu     = c;
    b.mem     = m;
    b.cpu_use = used_cpu;
    b.mem_use = used_mem;
    b.last    = last;
    expected_beats.push_back(b);
  endfunction

  function automatic void predict_admission(logic action, logic [7:0] id,
                                            logic [7:0] cpu, logic [31:0] mem);
    logic [7:0]  c;
    logic [31:0] m;
    entry_t      e;
    c = cpu;
    m = mem;
    if (action == ACT_ACQUIRE) begin
      if (c == 0) c = 1;
      if (c > cap_cpu) c = cap_cpu;
      if (m > cap_mem) m = cap_mem;
      if (wait_count == 0 && budget_fits(c, m)) begin
        used_cpu += c;
        used_mem += m;
        leases.push_back('{mem: m, cpu: c, id: id});
        push_beat(KIND_GRANT, id, c, m, 1'b1);
      end else if (wait_count >= QUEUE_DEPTH) begin
        push_beat(KIND_REJECTED, id, c, m, 1'b1);
      end else begin
        wait_q[(wait_head + wait_count) % QUEUE_DEPTH] = '{mem: m, cpu: c, id: id};
        wait_count++;
        push_beat(KIND_QUEUED, id, c, m, 1'b1);
      end
      return;
    end
    used_cpu = (used_cpu > cpu) ? used_cpu - cpu : '0;
    used_mem = (used_mem > mem) ? used_mem - mem : '0;
    push_beat(KIND_RELEASED, id, cpu, mem, 1'b0);
    // drain waiting heads in order while each one fits
    while (wait_count > 0) begin
      e = wait_q[wait_head];
      if (!budget_fits(e.cpu, e.mem)) break;
      used_cpu += e.cpu;
      used_mem += e.mem;
      leases.push_back(e);
      push_beat(KIND_GRANT, e.id, e.cpu, e.mem, 1'b0);
      wait_head = (wait_head + 1) % QUEUE_DEPTH;
      wait_count--;
    end
    expected_beats[expected_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic send_request(logic action, logic [7:0] id, logic [7:0] cpu,
                              logic [31:0] mem);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {mem, cpu, id};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_admission(action, id, cpu, mem);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    // a release with nothing to grant may still be finishing up
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic idx, logic [31:0] value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_CPU_CAPACITY) cap_cpu = (value[7:0] == 0) ? 8'd1 : value[7:0];
    else cap_mem = (value == 0) ? 32'd1 : value;
  endtask

  task automatic test_reset_defaults();
    send_request(ACT_ACQUIRE, 8'h00, 8'd0, 32'd0);
    send_request(ACT_ACQUIRE, 8'hff, 8'hff, 32'hffff_ffff);
    send_request(ACT_RELEASE, 8'h00, 8'd1, 32'd0);
    // over-release saturates at zero
    send_request(ACT_RELEASE, 8'hff, 8'hff, 32'hffff_ffff);
  endtask

  task automatic test_queue_overflow();
    write_capacity(CFG_CPU_CAPACITY, 32'd16);
    write_capacity(CFG_MEM_CAPACITY, 32'hffff_ffff);
    send_request(ACT_ACQUIRE, 8'h10, 8'd16, 32'h8000_0000);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_request(ACT_ACQUIRE, 8'(8'h20 + i), 8'd1, $urandom_range(0, 32'h0fff_ffff));
    send_request(ACT_ACQUIRE, 8'h5a, 8'd1, 32'd1);
    // one release grants the whole queue
    send_request(ACT_RELEASE, 8'h10, 8'd16, 32'h8000_0000);
    send_request(ACT_RELEASE, 8'h11, 8'd16, 32'hffff_ffff);
  endtask

  task automatic test_capacity_extremes();
    write_capacity(CFG_CPU_CAPACITY, 32'h0000_0100);
    write_capacity(CFG_MEM_CAPACITY, 32'd0);
    send_request(ACT_ACQUIRE, 8'h31, 8'd200, 32'd77);
    send_request(ACT_RELEASE, 8'h31, 8'd1, 32'd1);
    write_capacity(CFG_CPU_CAPACITY, 32'd255);
    write_capacity(CFG_MEM_CAPACITY, 32'hffff_ffff);
    send_request(ACT_ACQUIRE, 8'h32, 8'd255, 32'hffff_ffff);
    send_request(ACT_ACQUIRE, 8'h33, 8'd1, 32'd0);
    send_request(ACT_RELEASE, 8'h32, 8'd255, 32'hffff_ffff);
    send_request(ACT_RELEASE, 8'h33, 8'd1, 32'd0);
    // head blocked after the capacity drops below its need
    write_capacity(CFG_CPU_CAPACITY, 32'd2);
    send_request(ACT_ACQUIRE, 8'h34, 8'd2, 32'd0);
    send_request(ACT_ACQUIRE, 8'h35, 8'd2, 32'd0);
    write_capacity(CFG_CPU_CAPACITY, 32'd1);
    send_request(ACT_RELEASE, 8'h34, 8'd2, 32'd0);
    send_request(ACT_ACQUIRE, 8'h36, 8'd1, 32'd0);
    write_capacity(CFG_CPU_CAPACITY, 32'd2);
    send_request(ACT_RELEASE, 8'h37, 8'd0, 32'd0);
    send_request(ACT_RELEASE, 8'h35, 8'd2, 32'd0);
    send_request(ACT_RELEASE, 8'h36, 8'd1, 32'd0);
  endtask

  task automatic random_traffic(int unsigned n_items);
    logic [7:0]  c;
    logic [31:0] m;
    int unsigned idx;
    entry_t      e;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, (cap_cpu >> 1) + 1))
                                       : 8'($urandom_range(0, 255));
        m = ($urandom_range(0, 9) < 7) ? $urandom_range(0, cap_mem >> 2) : $urandom();
        send_request(ACT_ACQUIRE, 8'($urandom_range(0, 255)), c, m);
      end else if (leases.size() > 0 && $urandom_range(0, 9) < 8) begin
        idx = $urandom_range(0, leases.size() - 1);
        e = leases[idx];
        leases.delete(idx);
        send_request(ACT_RELEASE, e.id, e.cpu, e.mem);
      end else begin
        send_request(ACT_RELEASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     $urandom());
      end
    end
  endtask

  task automatic test_random_phases();
    logic [7:0]  cpu_set [5];
    logic [31:0] mem_set [5];
    cpu_set = '{8'd8, 8'd1, 8'd255, 8'($urandom_range(1, 255)), 8'd3};
    mem_set = '{32'h4000_0000, 32'd1, 32'hffff_ffff, $urandom(), 32'd1000};
    for (int p = 0; p < 5; p++) begin
      write_capacity(CFG_CPU_CAPACITY, {24'd0, cpu_set[p]});
      write_capacity(CFG_MEM_CAPACITY, mem_set[p]);
      gaps_on = (p != 2);
      random_traffic(34);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    gaps_on = 1'b0;
    rx_hold_req = 300;
    random_traffic(24);
    gaps_on = 1'b1;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always begin : rx_side
    int unsigned hold;
    @(posedge clk_i);
    if (rx_hold_req > 0) begin
      hold = rx_hold_req;
      rx_hold_req = 0;
      m_axis_tready <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end else begin
      hold = pick_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
    m_axis_tready <= 1'b1;
  end

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    admit_beat_t b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d id %0h", m_axis_tuser, m_axis_tdata[7:0]);
        errors++;
      end else begin
        b = expected_beats.pop_front();
        check_field("kind", 32'(b.kind), 32'(m_axis_tuser));
        check_field("granted_id", 32'(b.id), 32'(m_axis_tdata[7:0]));
        check_field("granted_cpu", 32'(b.cpu), 32'(m_axis_tdata[15:8]));
        check_field("granted_memory", b.mem, m_axis_tdata[47:16]);
        check_field("cpu_in_use", 32'(b.cpu_use), 32'(m_axis_tdata[55:48]));
        check_field("memory_in_use", b.mem_use, m_axis_tdata[87:56]);
        check_field("last", 32'(b.last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_defaults();
    test_queue_overflow();
    test_capacity_extremes();
    test_output_backpressure();
    test_random_phases();
    wait_drained();
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ftba_pkg.sv
rtl/ftba_ctrl.sv
rtl/ftba_dp.sv
rtl/fifo_two_budget_admission_unit.sv
tb/sv/fifo_two_budget_admission_unit_tb.sv
